/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the vector rotation RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define QVR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form of the above.
`define QVR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  `QVR_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

/* src/qvr_pkg.sv */
// ----------------------------------------------------------------------------
// Quaternion vector rotation package
// Defaults, register indexes and axis helpers shared by the rotation RTL.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 12;

  localparam int NUM_AXES  = 3;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUAT_REAL = 2'd0,
    CFG_QUAT_I    = 2'd1,
    CFG_QUAT_J    = 2'd2,
    CFG_QUAT_K    = 2'd3
  } cfg_idx_e;

  // Cyclic neighbours of each axis, used to build the cross product.
  localparam int AX_NEXT [NUM_AXES] = '{1, 2, 0};
  localparam int AX_PREV [NUM_AXES] = '{2, 0, 1};

endpackage

/* src/qvr_product.sv */
// ----------------------------------------------------------------------------
// Rotation numerator
// Five stages forming the exact integer numerator P and the squared norm N.
// ----------------------------------------------------------------------------
module qvr_product import qvr_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [DATA_WIDTH-1:0]    vec_i [NUM_AXES],
  input  logic signed [DATA_WIDTH-1:0]    quat_w_i,
  input  logic signed [DATA_WIDTH-1:0]    quat_u_i [NUM_AXES],
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [3*DATA_WIDTH+3:0]  p_o [NUM_AXES],
  output logic        [2*DATA_WIDTH:0]    n_o
);

  localparam int PrW  = 2 * DATA_WIDTH;
  localparam int NsW  = 2 * DATA_WIDTH + 2;
  localparam int NW   = 2 * DATA_WIDTH + 1;
  localparam int SW   = 2 * DATA_WIDTH + 1;
  localparam int D2W  = 2 * DATA_WIDTH + 2;
  localparam int TW   = 3 * DATA_WIDTH + 2;
  localparam int PW   = 3 * DATA_WIDTH + 4;
  localparam int NStg = 5;

  logic [NStg-1:0] vld_q;
  logic            adv;

  // Stage 0: input register.
  logic signed [DATA_WIDTH-1:0] vec0_q [NUM_AXES];
  // Stage 1: all pairwise products and the squares of the quaternion.
  logic signed [PrW-1:0]        uv_d  [NUM_AXES][NUM_AXES];
  logic signed [PrW-1:0]        uv_q  [NUM_AXES][NUM_AXES];
  logic signed [PrW-1:0]        sq_d  [NUM_AXES+1];
  logic signed [PrW-1:0]        sq_q  [NUM_AXES+1];
  logic signed [DATA_WIDTH-1:0] vec1_q [NUM_AXES];
  // Stage 2: scalar, norm, doubled dot and cross products.
  logic signed [NsW-1:0]        nsum;
  logic signed [SW-1:0]         s_d, s_q;
  logic        [NW-1:0]         n2_d, n2_q;
  logic signed [D2W-1:0]        d2_d, d2_q;
  logic signed [D2W-1:0]        c2_d [NUM_AXES];
  logic signed [D2W-1:0]        c2_q [NUM_AXES];
  logic signed [DATA_WIDTH-1:0] vec2_q [NUM_AXES];
  // Stage 3: the three terms of each numerator component.
  logic signed [TW-1:0]         sx_q [NUM_AXES];
  logic signed [TW-1:0]         du_q [NUM_AXES];
  logic signed [TW-1:0]         cw_q [NUM_AXES];
  logic        [NW-1:0]         n3_q;
  // Stage 4: numerator.
  logic signed [PW-1:0]         p_q  [NUM_AXES];
  logic        [NW-1:0]         n4_q;

  assign adv        = !vld_q[NStg-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  always_comb begin
    sq_d[0] = PrW'(quat_w_i) * PrW'(quat_w_i);
    for (int a = 0; a < NUM_AXES; a++) begin
      sq_d[a+1] = PrW'(quat_u_i[a]) * PrW'(quat_u_i[a]);
      for (int b = 0; b < NUM_AXES; b++) begin
        uv_d[a][b] = PrW'(quat_u_i[a]) * PrW'(vec0_q[b]);
      end
    end
  end

  always_comb begin
    nsum = NsW'(sq_q[0]) + NsW'(sq_q[1]) + NsW'(sq_q[2]) + NsW'(sq_q[3]);
    // A zero quaternion divides by one; the numerator is then zero as well.
    n2_d = (nsum == '0) ? NW'(1) : nsum[NW-1:0];
    s_d  = SW'(sq_q[0]) - SW'(sq_q[1]) - SW'(sq_q[2]) - SW'(sq_q[3]);
    d2_d = (D2W'(uv_q[0][0]) + D2W'(uv_q[1][1]) + D2W'(uv_q[2][2])) <<< 1;
    for (int a = 0; a < NUM_AXES; a++) begin
      c2_d[a] = (D2W'(uv_q[AX_NEXT[a]][AX_PREV[a]])
                 - D2W'(uv_q[AX_PREV[a]][AX_NEXT[a]])) <<< 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        vec0_q[a] <= vec_i[a];
        vec1_q[a] <= vec0_q[a];
        vec2_q[a] <= vec1_q[a];
        for (int b = 0; b < NUM_AXES; b++) begin
          uv_q[a][b] <= uv_d[a][b];
        end
        c2_q[a] <= c2_d[a];
        sx_q[a] <= TW'(s_q) * TW'(vec2_q[a]);
        du_q[a] <= TW'(d2_q) * TW'(quat_u_i[a]);
        cw_q[a] <= TW'(c2_q[a]) * TW'(quat_w_i);
        p_q[a]  <= PW'(sx_q[a]) + PW'(du_q[a]) + PW'(cw_q[a]);
      end
      for (int a = 0; a <= NUM_AXES; a++) begin
        sq_q[a] <= sq_d[a];
      end
      s_q  <= s_d;
      n2_q <= n2_d;
      d2_q <= d2_d;
      n3_q <= n2_q;
      n4_q <= n3_q;
    end
  end

  assign out_valid_o = vld_q[NStg-1];
  assign p_o         = p_q;
  assign n_o         = n4_q;

endmodule

/* src/qvr_divider.sv */
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division of |P| by N, one quotient bit per stage, three lanes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qvr_divider import qvr_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [3*DATA_WIDTH+3:0]  p_i [NUM_AXES],
  input  logic        [2*DATA_WIDTH:0]    n_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic        [DATA_WIDTH:0]      q_o   [NUM_AXES],
  output logic        [2*DATA_WIDTH:0]    rem_o [NUM_AXES],
  output logic                            neg_o [NUM_AXES],
  output logic                            ovf_o [NUM_AXES],
  output logic        [2*DATA_WIDTH:0]    n_o
);

  localparam int NW   = 2 * DATA_WIDTH + 1;
  localparam int PW   = 3 * DATA_WIDTH + 4;
  localparam int QW   = DATA_WIDTH + 1;
  localparam int TopW = PW - QW;
  localparam int NStg = QW + 1;

  logic [NStg-1:0] vld_q;
  logic            adv;

  logic [NW-1:0]   n_q   [NStg];
  logic [NW-1:0]   rem_q [NStg][NUM_AXES];
  logic [QW-1:0]   low_q [NStg][NUM_AXES];
  logic [QW-1:0]   quo_q [NStg][NUM_AXES];
  logic            neg_q [NStg][NUM_AXES];
  logic            ovf_q [NStg][NUM_AXES];

  logic            neg_s [NUM_AXES];
  logic [PW-1:0]   mag_s [NUM_AXES];
  logic [TopW-1:0] top_s [NUM_AXES];
  logic            ovf_s [NUM_AXES];

  logic [NW:0]     trial [NStg][NUM_AXES];
  logic [NW:0]     diff  [NStg][NUM_AXES];
  logic            ge    [NStg][NUM_AXES];

  assign adv        = !vld_q[NStg-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  // Setup: magnitude, and an early overflow check so that the remaining
  // quotient fits the bits that the stages below produce.
  always_comb begin
    for (int l = 0; l < NUM_AXES; l++) begin
      neg_s[l] = p_i[l][PW-1];
      mag_s[l] = neg_s[l] ? PW'(-p_i[l]) : PW'(p_i[l]);
      top_s[l] = mag_s[l][PW-1:QW];
      ovf_s[l] = top_s[l] >= TopW'(n_i);
    end
  end

  always_comb begin
    for (int k = 0; k < NStg; k++) begin
      for (int l = 0; l < NUM_AXES; l++) begin
        trial[k][l] = {rem_q[k][l], low_q[k][l][QW-1]};
        diff[k][l]  = trial[k][l] - {1'b0, n_q[k]};
        ge[k][l]    = trial[k][l] >= {1'b0, n_q[k]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n_q[0] <= n_i;
      for (int l = 0; l < NUM_AXES; l++) begin
        rem_q[0][l] <= ovf_s[l] ? '0 : top_s[l][NW-1:0];
        low_q[0][l] <= mag_s[l][QW-1:0];
        quo_q[0][l] <= '0;
        neg_q[0][l] <= neg_s[l];
        ovf_q[0][l] <= ovf_s[l];
      end
      for (int k = 1; k < NStg; k++) begin
        n_q[k] <= n_q[k-1];
        for (int l = 0; l < NUM_AXES; l++) begin
          rem_q[k][l] <= ge[k-1][l] ? diff[k-1][l][NW-1:0] : trial[k-1][l][NW-1:0];
          low_q[k][l] <= {low_q[k-1][l][QW-2:0], 1'b0};
          quo_q[k][l] <= {quo_q[k-1][l][QW-2:0], ge[k-1][l]};
          neg_q[k][l] <= neg_q[k-1][l];
          ovf_q[k][l] <= ovf_q[k-1][l];
        end
      end
    end
  end

  assign out_valid_o = vld_q[NStg-1];
  assign n_o         = n_q[NStg-1];
  always_comb begin
    for (int l = 0; l < NUM_AXES; l++) begin
      q_o[l]   = quo_q[NStg-1][l];
      rem_o[l] = rem_q[NStg-1][l];
      neg_o[l] = neg_q[NStg-1][l];
      ovf_o[l] = ovf_q[NStg-1][l];
    end
  end

  // The remainder leaving the last stage is always below the divisor.
  `QVR_ASSERT_IMP(a_rem_below_n_x, clk_i, rst_ni, vld_q[NStg-1], rem_q[NStg-1][0] < n_q[NStg-1], "divider x remainder not below divisor")
  `QVR_ASSERT_IMP(a_rem_below_n_y, clk_i, rst_ni, vld_q[NStg-1], rem_q[NStg-1][1] < n_q[NStg-1], "divider y remainder not below divisor")
  `QVR_ASSERT_IMP(a_rem_below_n_z, clk_i, rst_ni, vld_q[NStg-1], rem_q[NStg-1][2] < n_q[NStg-1], "divider z remainder not below divisor")

endmodule

/* src/qvr_round.sv */
// ----------------------------------------------------------------------------
// Rounding and saturation
// Rounds the quotient to nearest, restores the sign and clips to range.
// ----------------------------------------------------------------------------
module qvr_round import qvr_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic        [DATA_WIDTH:0]   q_i   [NUM_AXES],
  input  logic        [2*DATA_WIDTH:0] rem_i [NUM_AXES],
  input  logic                         neg_i [NUM_AXES],
  input  logic                         ovf_i [NUM_AXES],
  input  logic        [2*DATA_WIDTH:0] n_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] rot_o [NUM_AXES],
  output logic                         sat_o
);

  localparam int RW = DATA_WIDTH + 2;
  localparam logic [RW-1:0] DMaxR = RW'((64'(1) << (DATA_WIDTH - 1)) - 64'(1));
  localparam logic [RW-1:0] DMinMagR = RW'(64'(1) << (DATA_WIDTH - 1));
  localparam logic signed [DATA_WIDTH-1:0] DMax = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DMin = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic [1:0] vld_q;
  logic       adv;

  logic                         rnd     [NUM_AXES];
  logic [RW-1:0]                qr_q    [NUM_AXES];
  logic                         neg_q   [NUM_AXES];
  logic                         ovf_q   [NUM_AXES];
  logic                         lsat    [NUM_AXES];
  logic [DATA_WIDTH-1:0]        qr_t    [NUM_AXES];
  logic signed [DATA_WIDTH-1:0] rot_d   [NUM_AXES];
  logic signed [DATA_WIDTH-1:0] rot_q   [NUM_AXES];
  logic                         sat_d, sat_q;

  assign adv        = !vld_q[1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[0], in_valid_i};
    end
  end

  // Ties go away from zero because rounding is done on the magnitude.
  always_comb begin
    for (int l = 0; l < NUM_AXES; l++) begin
      rnd[l] = {rem_i[l], 1'b0} >= {1'b0, n_i};
    end
  end

  always_comb begin
    sat_d = 1'b0;
    for (int l = 0; l < NUM_AXES; l++) begin
      // The magnitude one above the positive limit is still legal when negative.
      lsat[l] = ovf_q[l] || ((qr_q[l] > DMaxR) && !(neg_q[l] && (qr_q[l] == DMinMagR)));
      qr_t[l] = qr_q[l][DATA_WIDTH-1:0];
      if (lsat[l]) begin
        rot_d[l] = neg_q[l] ? DMin : DMax;
      end else begin
        rot_d[l] = neg_q[l] ? -$signed(qr_t[l]) : $signed(qr_t[l]);
      end
      sat_d = sat_d || lsat[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < NUM_AXES; l++) begin
        qr_q[l]  <= RW'(q_i[l]) + RW'(rnd[l]);
        neg_q[l] <= neg_i[l];
        ovf_q[l] <= ovf_i[l];
        rot_q[l] <= rot_d[l];
      end
      sat_q <= sat_d;
    end
  end

  assign out_valid_o = vld_q[1];
  assign rot_o       = rot_q;
  assign sat_o       = sat_q;

endmodule

/* src/quaternion_vector_rotate_core.sv */
// ----------------------------------------------------------------------------
// Quaternion vector rotation core
// Rotates a stream of fixed-point 3D vectors by a programmed quaternion.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  vec      in         vec_valid_i / vec_ready_o  vec_x_i, vec_y_i, vec_z_i
//  rot      out        rot_valid_o / rot_ready_i  rot_x_o, rot_y_o, rot_z_o, saturated_o
//  cfg      in         cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// One vector beat per cycle is accepted when not stalled; the result beat follows after
// DATA_WIDTH + 9 register stages (25 at the default width), set by the
// one-bit-per-stage divider. Reset clears the valid bits and loads the
// identity quaternion. A stall on the result side halts each of the three
// segments once its last stage holds a waiting beat; a segment whose last
// stage is empty keeps taking new beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_vector_rotate_core import qvr_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [DATA_WIDTH-1:0]        cfg_data_i,
  input  logic                         vec_valid_i,
  output logic                         vec_ready_o,
  input  logic signed [DATA_WIDTH-1:0] vec_x_i,
  input  logic signed [DATA_WIDTH-1:0] vec_y_i,
  input  logic signed [DATA_WIDTH-1:0] vec_z_i,
  output logic                         rot_valid_o,
  input  logic                         rot_ready_i,
  output logic signed [DATA_WIDTH-1:0] rot_x_o,
  output logic signed [DATA_WIDTH-1:0] rot_y_o,
  output logic signed [DATA_WIDTH-1:0] rot_z_o,
  output logic                         saturated_o
);

  localparam logic [DATA_WIDTH-1:0] QuatRealReset = DATA_WIDTH'(64'(1) << FRAC_BITS);
  localparam logic signed [DATA_WIDTH-1:0] DMax = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DMin = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [DATA_WIDTH-1:0]   quat_w_q;
  logic signed [DATA_WIDTH-1:0]   quat_u_q [NUM_AXES];
  logic signed [DATA_WIDTH-1:0]   vec_in   [NUM_AXES];

  logic                           prod_valid, prod_ready;
  logic signed [3*DATA_WIDTH+3:0] prod_p   [NUM_AXES];
  logic        [2*DATA_WIDTH:0]   prod_n;

  logic                           div_valid, div_ready;
  logic        [DATA_WIDTH:0]     div_q    [NUM_AXES];
  logic        [2*DATA_WIDTH:0]   div_rem  [NUM_AXES];
  logic                           div_neg  [NUM_AXES];
  logic                           div_ovf  [NUM_AXES];
  logic        [2*DATA_WIDTH:0]   div_n;

  logic signed [DATA_WIDTH-1:0]   rot      [NUM_AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_w_q <= QuatRealReset;
      quat_u_q <= '{default: '0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_QUAT_REAL: quat_w_q    <= cfg_data_i;
        CFG_QUAT_I:    quat_u_q[0] <= cfg_data_i;
        CFG_QUAT_J:    quat_u_q[1] <= cfg_data_i;
        CFG_QUAT_K:    quat_u_q[2] <= cfg_data_i;
        default:       quat_w_q    <= quat_w_q;
      endcase
    end
  end

  assign vec_in[0] = vec_x_i;
  assign vec_in[1] = vec_y_i;
  assign vec_in[2] = vec_z_i;

  qvr_product #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_product (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vec_valid_i),
    .in_ready_o (vec_ready_o),
    .vec_i      (vec_in),
    .quat_w_i   (quat_w_q),
    .quat_u_i   (quat_u_q),
    .out_valid_o(prod_valid),
    .out_ready_i(prod_ready),
    .p_o        (prod_p),
    .n_o        (prod_n)
  );

  qvr_divider #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (prod_valid),
    .in_ready_o (prod_ready),
    .p_i        (prod_p),
    .n_i        (prod_n),
    .out_valid_o(div_valid),
    .out_ready_i(div_ready),
    .q_o        (div_q),
    .rem_o      (div_rem),
    .neg_o      (div_neg),
    .ovf_o      (div_ovf),
    .n_o        (div_n)
  );

  qvr_round #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_round (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (div_valid),
    .in_ready_o (div_ready),
    .q_i        (div_q),
    .rem_i      (div_rem),
    .neg_i      (div_neg),
    .ovf_i      (div_ovf),
    .n_i        (div_n),
    .out_valid_o(rot_valid_o),
    .out_ready_i(rot_ready_i),
    .rot_o      (rot),
    .sat_o      (saturated_o)
  );

  assign rot_x_o = rot[0];
  assign rot_y_o = rot[1];
  assign rot_z_o = rot[2];

  // The input can only be held off when a result beat is waiting at the output.
  `QVR_ASSERT_IMP(a_stall_from_output, clk_i, rst_ni, !vec_ready_o, rot_valid_o, "input stalled with no result waiting")
  // A clipped result carries at least one component at a range limit.
  `QVR_ASSERT_IMP(a_sat_at_limit, clk_i, rst_ni, rot_valid_o && saturated_o, rot_x_o == DMax || rot_x_o == DMin || rot_y_o == DMax || rot_y_o == DMin || rot_z_o == DMax || rot_z_o == DMin, "saturated flag without a clipped component")
  // A result beat that is held off stays offered with its payload unchanged.
  `QVR_ASSERT_IMP(a_rot_hold, clk_i, rst_ni, $past(rot_valid_o && !rot_ready_i), rot_valid_o && $stable(rot_x_o) && $stable(rot_y_o) && $stable(rot_z_o) && $stable(saturated_o), "held result beat changed")

endmodule
